// ===== sv/stereo_linear_fade_ramp_defines.svh =====
// assertion macros for the stereo linear fade ramp
`ifndef STEREO_LINEAR_FADE_RAMP_DEFINES_SVH
`define STEREO_LINEAR_FADE_RAMP_DEFINES_SVH

`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define SFR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sfr assertion failed");
// condition that must never be seen out of reset
`define SFR_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sfr forbidden condition seen");
`else
`define SFR_ASSERT(label, prop)
`define SFR_NEVER(label, cond)
`endif

`endif

// ===== sv/sfr_pkg.sv =====
// shared types and constants of the stereo linear fade ramp
`timescale 1ns / 1ps
package sfr_pkg;

  localparam int FIELD_BITS = 32;
  localparam int STEP_BITS  = 25;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 3;

  localparam logic [STEP_BITS-1:0] GAIN_STEP_RESET = 25'd3804;

  // register index, taken from address bit 2
  typedef enum logic {
    REG_GAIN_STEP = 1'b0,
    REG_RAMP_DIR  = 1'b1
  } sfr_reg_t;

  // per-frame control from the gain sequencer to the lanes
  typedef struct packed {
    logic scale;
    logic mute;
    logic busy;
  } sfr_frame_ctl_t;

endpackage

// ===== sv/sfr_if.sv =====
// valid/ready channel interfaces for input frames and scaled frames
`timescale 1ns / 1ps
interface sfr_in_if import sfr_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] left_sample;
  logic signed [FIELD_BITS-1:0] right_sample;
  logic                         restart_ramp;

  modport source (output valid, output left_sample, output right_sample,
                  output restart_ramp, input ready);
  modport sink (input valid, input left_sample, input right_sample,
                input restart_ramp, output ready);
endinterface

interface sfr_out_if import sfr_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] left_scaled;
  logic signed [FIELD_BITS-1:0] right_scaled;
  logic                         ramp_busy;

  modport source (output valid, output left_scaled, output right_scaled,
                  output ramp_busy, input ready);
  modport sink (input valid, input left_scaled, input right_scaled,
                input ramp_busy, output ready);
endinterface

// ===== sv/sfr_gain_ctrl.sv =====
// running gain sequencer: restart, step and end of ramp per accepted frame
`timescale 1ns / 1ps
module sfr_gain_ctrl import sfr_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_fire,
  input  logic                    restart_ramp,
  input  logic [STEP_BITS-1:0]    gain_step,
  input  logic                    ramp_dir,
  output logic [GAIN_FRAC_BITS:0] gain_used,
  output sfr_frame_ctl_t          frame_ctl
);

  localparam int LW    = GAIN_FRAC_BITS + 2;
  localparam int SUM_W = ((LW > STEP_BITS) ? LW : STEP_BITS) + 1;
  localparam logic [LW-1:0] GainOne = {{(LW-1){1'b0}}, 1'b1} << GAIN_FRAC_BITS;

  logic [LW-1:0]    level_r, level_nxt;
  logic             ramping_r, ramping_nxt;
  logic             silenced_r, silenced_nxt;
  logic             restart;
  logic [LW-1:0]    eff_level;
  logic             eff_ramp;
  logic             eff_sil;
  logic [SUM_W-1:0] sum;

  always_comb begin
    restart   = in_fire && restart_ramp;
    eff_level = restart ? (ramp_dir ? GainOne : '0) : level_r;
    eff_ramp  = restart || ramping_r;
    eff_sil   = restart ? 1'b0 : silenced_r;

    level_nxt    = eff_level;
    ramping_nxt  = eff_ramp;
    silenced_nxt = eff_sil;
    sum          = SUM_W'(eff_level) + SUM_W'(gain_step);

    if (eff_ramp) begin
      if (!ramp_dir) begin
        if (sum >= SUM_W'(GainOne)) begin
          level_nxt   = GainOne;
          ramping_nxt = 1'b0;
        end else begin
          level_nxt = sum[LW-1:0];
        end
      end else begin
        // underflow ends the fade-out and mutes; landing on zero does not
        if (SUM_W'(gain_step) > SUM_W'(eff_level)) begin
          level_nxt    = '0;
          ramping_nxt  = 1'b0;
          silenced_nxt = 1'b1;
        end else begin
          level_nxt = eff_level - LW'(gain_step);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= '0;
      ramping_r  <= 1'b0;
      silenced_r <= 1'b0;
    end else if (in_fire) begin
      level_r    <= level_nxt;
      ramping_r  <= ramping_nxt;
      silenced_r <= silenced_nxt;
    end
  end

  // gain never exceeds 1.0, so the top bit of the level is not needed here
  assign gain_used       = eff_level[GAIN_FRAC_BITS:0];
  assign frame_ctl.scale = eff_ramp;
  assign frame_ctl.mute  = !eff_ramp && eff_sil;
  assign frame_ctl.busy  = ramping_nxt;

endmodule

// ===== sv/sfr_lane.sv =====
// one channel lane: magnitude, gain multiply, round and saturate
`timescale 1ns / 1ps
module sfr_lane import sfr_pkg::*; #(
  parameter int SAMPLE_BITS    = 32,
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic                    clk,
  input  logic                    ld_a,
  input  logic                    ld_b,
  input  logic [FIELD_BITS-1:0]   sample,
  input  logic [GAIN_FRAC_BITS:0] gain,
  input  sfr_frame_ctl_t          frame_ctl,
  output logic [FIELD_BITS-1:0]   result
);

  localparam int GW = GAIN_FRAC_BITS + 1;
  localparam int PW = SAMPLE_BITS + GW;
  localparam int QW = PW + 1 - GAIN_FRAC_BITS;
  localparam logic [PW:0] HalfW = {{PW{1'b0}}, 1'b1} << (GAIN_FRAC_BITS - 1);
  localparam logic [QW-1:0] MinMagQ = {{(QW-1){1'b0}}, 1'b1} << (SAMPLE_BITS - 1);
  localparam logic [QW-1:0] MaxQ = MinMagQ - 1'b1;

  logic [SAMPLE_BITS-1:0] samp_in;
  logic [SAMPLE_BITS-1:0] mag_in;

  logic [SAMPLE_BITS-1:0] samp_a_r;
  logic [SAMPLE_BITS-1:0] mag_a_r;
  logic [GW-1:0]          gain_a_r;
  sfr_frame_ctl_t         ctl_a_r;

  logic [SAMPLE_BITS-1:0] samp_b_r;
  logic [PW-1:0]          prod_b_r;
  sfr_frame_ctl_t         ctl_b_r;

  logic [PW:0]            rnd_sum;
  logic [PW:0]            rnd_diff;
  logic                   below_half;
  logic [QW-1:0]          q_pos;
  logic [QW-1:0]          q_neg;
  logic [SAMPLE_BITS-1:0] scaled;
  logic [SAMPLE_BITS-1:0] picked;

  assign samp_in = sample[SAMPLE_BITS-1:0];
  assign mag_in  = samp_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(~samp_in + 1'b1) : samp_in;

  always_ff @(posedge clk) begin
    if (ld_a) begin
      samp_a_r <= samp_in;
      mag_a_r  <= mag_in;
      gain_a_r <= gain;
      ctl_a_r  <= frame_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_b) begin
      samp_b_r <= samp_a_r;
      prod_b_r <= PW'(mag_a_r) * PW'(gain_a_r);
      ctl_b_r  <= ctl_a_r;
    end
  end

  // positives round half up, negatives half toward zero; below half is 0
  always_comb begin
    rnd_sum    = {1'b0, prod_b_r} + HalfW;
    rnd_diff   = {1'b0, prod_b_r} - HalfW;
    below_half = {1'b0, prod_b_r} < HalfW;
    q_pos      = rnd_sum[PW:GAIN_FRAC_BITS];
    q_neg      = below_half ? '0 : rnd_diff[PW:GAIN_FRAC_BITS];

    if (!samp_b_r[SAMPLE_BITS-1]) begin
      scaled = (q_pos > MaxQ) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}} : q_pos[SAMPLE_BITS-1:0];
    end else begin
      scaled = (q_neg > MinMagQ) ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                 : SAMPLE_BITS'(~q_neg[SAMPLE_BITS-1:0] + 1'b1);
    end

    if (ctl_b_r.scale) begin
      picked = scaled;
    end else if (ctl_b_r.mute) begin
      picked = '0;
    end else begin
      picked = samp_b_r;
    end
  end

  assign result = FIELD_BITS'(signed'(picked));

endmodule

// ===== sv/stereo_linear_fade_ramp.sv =====
// top level of the stereo linear fade ramp: config, gain sequencer, lanes, merge
//
//   port     direction  handshake            word
//   in_ch    sink       valid/ready          left_sample, right_sample, restart_ramp
//   out_ch   source     valid/ready          left_scaled, right_scaled, ramp_busy
//   cfg_*    slave      apb, pready tied 1   gain_step @0x0, ramp_direction @0x4
//
// one frame per cycle while the output is not stalled; each frame passes lane stages a and b, then the merge stage
// the gain update is a registered add/compare loop, the multiply sits in its own stage
// every stage moves when the one after it is empty or moving, so bubbles are absorbed
// a stalled output holds the last stage; input stops only when all three stages are full
// reset clears the pipeline valids, the ramp state and loads the register reset values
`timescale 1ns / 1ps
`include "stereo_linear_fade_ramp_defines.svh"
module stereo_linear_fade_ramp import sfr_pkg::*; #(
  parameter int SAMPLE_BITS    = 32,
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  sfr_in_if.sink                   in_ch,
  sfr_out_if.source                out_ch,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  localparam logic [GAIN_FRAC_BITS:0] GainOne =
    {{GAIN_FRAC_BITS{1'b0}}, 1'b1} << GAIN_FRAC_BITS;

  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic                 dir_r, dir_nxt;
  logic                 cfg_wr;
  sfr_reg_t             cfg_sel;

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  logic in_fire;
  logic busy1_r, busy2_r, busy3_r;

  logic [GAIN_FRAC_BITS:0] gain_used;
  sfr_frame_ctl_t          frame_ctl;
  logic [FIELD_BITS-1:0]   left_res, right_res;
  logic [FIELD_BITS-1:0]   left_r, right_r;

  // configuration registers, word addressed by bit 2
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = sfr_reg_t'(cfg_paddr[2]);

  always_comb begin
    step_nxt   = step_r;
    dir_nxt    = dir_r;
    cfg_prdata = '0;
    case (cfg_sel)
      REG_GAIN_STEP: begin
        cfg_prdata = CFG_DATA_BITS'(step_r);
        if (cfg_wr) step_nxt = cfg_pwdata[STEP_BITS-1:0];
      end
      REG_RAMP_DIR: begin
        cfg_prdata = CFG_DATA_BITS'(dir_r);
        if (cfg_wr) dir_nxt = cfg_pwdata[0];
      end
      default: begin
        cfg_prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= GAIN_STEP_RESET;
      dir_r  <= 1'b0;
    end else begin
      step_r <= step_nxt;
      dir_r  <= dir_nxt;
    end
  end

  // pipeline flow control
  assign en3         = !v3_r || out_ch.ready;
  assign en2         = !v2_r || en3;
  assign en1         = !v1_r || en2;
  assign in_ch.ready = en1;
  assign in_fire     = in_ch.valid && en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  sfr_gain_ctrl #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_gain_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .restart_ramp (in_ch.restart_ramp),
    .gain_step    (step_r),
    .ramp_dir     (dir_r),
    .gain_used    (gain_used),
    .frame_ctl    (frame_ctl)
  );

  sfr_lane #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_lane_left (
    .clk       (clk),
    .ld_a      (en1),
    .ld_b      (en2),
    .sample    (in_ch.left_sample),
    .gain      (gain_used),
    .frame_ctl (frame_ctl),
    .result    (left_res)
  );

  sfr_lane #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_lane_right (
    .clk       (clk),
    .ld_a      (en1),
    .ld_b      (en2),
    .sample    (in_ch.right_sample),
    .gain      (gain_used),
    .frame_ctl (frame_ctl),
    .result    (right_res)
  );

  // merge stage: both lanes and the ramp status into one output word
  always_ff @(posedge clk) begin
    if (en1) busy1_r <= frame_ctl.busy;
    if (en2) busy2_r <= busy1_r;
    if (en3) begin
      busy3_r <= busy2_r;
      left_r  <= left_res;
      right_r <= right_res;
    end
  end

  assign out_ch.valid        = v3_r;
  assign out_ch.left_scaled  = left_r;
  assign out_ch.right_scaled = right_r;
  assign out_ch.ramp_busy    = busy3_r;

  `SFR_ASSERT(a_gain_le_one, in_fire |-> (gain_used <= GainOne))
  `SFR_NEVER(a_scale_and_mute, in_fire && frame_ctl.scale && frame_ctl.mute)
  `SFR_ASSERT(a_fade_out_start, (in_fire && in_ch.restart_ramp && dir_r) |-> (gain_used == GainOne))
  `SFR_ASSERT(a_stall_only_full, !in_ch.ready |-> (v1_r && v2_r && v3_r && !out_ch.ready))

endmodule
